// ===== hw/rtl/sqlhl_pkg.sv =====
package sqlhl_pkg;

  // Default sizes, handed down from the top level
  localparam int POS_BITS_DEFAULT        = 16;
  localparam int MAX_KEYWORD_LEN_DEFAULT = 11;

  // Fixed width of the position fields in a result
  localparam int OUT_POS_BITS = 16;

  // Keyword table: text is left aligned and padded with spaces
  localparam int KW_COUNT   = 19;
  localparam int KW_MAX_LEN = 11;

  typedef logic [8*KW_MAX_LEN-1:0] kw_text_t;

  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    "CONSTRUCTOR", "OVERRIDING ", "MEMBER     ", "FUNCTION   ", "PROCEDURE  ",
    "NULL       ", "IS         ", "AS         ", "SELF       ", "NOT        ",
    "OR         ", "AND        ", "RETURN     ", "BEGIN      ", "END        ",
    "LOOP       ", "IF         ", "THEN       ", "ELSE       "
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd11, 4'd10, 4'd6, 4'd8, 4'd9, 4'd4, 4'd2, 4'd2, 4'd4, 4'd3,
    4'd2, 4'd3, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2, 4'd4, 4'd4
  };

  // Span styles
  localparam logic [1:0] STYLE_BLUE    = 2'd0;
  localparam logic [1:0] STYLE_RED     = 2'd1;
  localparam logic [1:0] STYLE_COMMENT = 2'd2;

  localparam logic [1:0] KW_STYLE [KW_COUNT] = '{
    STYLE_BLUE, STYLE_BLUE, STYLE_BLUE, STYLE_BLUE, STYLE_BLUE,
    STYLE_BLUE, STYLE_BLUE, STYLE_BLUE, STYLE_BLUE, STYLE_BLUE,
    STYLE_BLUE, STYLE_BLUE, STYLE_BLUE, STYLE_RED,  STYLE_RED,
    STYLE_RED,  STYLE_RED,  STYLE_RED,  STYLE_RED
  };

  // Table rows the member tracker looks for
  localparam int KW_MEMBER    = 2;
  localparam int KW_FUNCTION  = 3;
  localparam int KW_PROCEDURE = 4;

  // Bytes with a role in comment detection
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_BLOCK,
    MODE_LINE
  } lex_mode_t;

  typedef enum logic [1:0] {
    TRK_NONE,
    TRK_MEMBER,
    TRK_PROCFUNC
  } member_track_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_of_text;
  } sqlhl_in_t;

  typedef struct packed {
    logic                    span_valid;
    logic [1:0]              span_style;
    logic [OUT_POS_BITS-1:0] span_begin;
    logic [OUT_POS_BITS-1:0] span_end;
    logic                    member_name_valid;
  } sqlhl_out_t;

  // Keyword match status from the matcher to the lexer core
  typedef struct packed {
    logic       hit;
    logic [1:0] style;
    logic       is_member;
    logic       is_procfunc;
  } kw_status_t;

  // Delimiter set; every other byte, zero included, is a word byte
  function automatic logic is_delim(input logic [7:0] c);
    logic d;
    case (c) inside
      8'h7E, 8'h27, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h2D, 8'h3D, 8'h2B, 8'h5C,
      8'h7C, 8'h2F, 8'h3F, 8'h2C, 8'h2E, 8'h5B, 8'h5D, 8'h7B,
      8'h7D, 8'h22, 8'h60, 8'h3B, 8'h0A, 8'h09, 8'h0D, 8'h20: d = 1'b1;
      default: d = 1'b0;
    endcase
    return d;
  endfunction

  // ASCII uppercase, a-z only
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] u;
    case (c) inside
      [8'h61:8'h7A]: u = c - 8'h20;
      default:       u = c;
    endcase
    return u;
  endfunction

endpackage

// ===== hw/rtl/sql_highlight_lexer_unit.sv =====
// A byte waits in the input register; its result is then loaded into the result register.
//   The lexer state loop and keyword compare are combinational.
// Throughput: one byte per cycle, held while a result waits untaken in the result register.
// Bytes that end neither a span nor a member name give no result.
// Reset (rst, synchronous): empties both registers and returns the lexer to idle at
//   position zero; the word buffer is not cleared.
module sql_highlight_lexer_unit #(
  parameter int POS_BITS        = sqlhl_pkg::POS_BITS_DEFAULT,
  parameter int MAX_KEYWORD_LEN = sqlhl_pkg::MAX_KEYWORD_LEN_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_ready,
  input  sqlhl_pkg::sqlhl_in_t  byte_item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output sqlhl_pkg::sqlhl_out_t result_item
);

  logic                  in_full;
  sqlhl_pkg::sqlhl_in_t  in_item;
  logic                  advance;
  logic                  core_hit;
  sqlhl_pkg::sqlhl_out_t core_res;

  // Stage moves when the result register is free or nothing is produced
  assign advance    = in_full && (!result_valid || result_ready || !core_hit);
  assign byte_ready = !in_full || advance;

  sqlhl_lex_core #(
    .POS_BITS       (POS_BITS),
    .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .res_hit(core_hit),
    .res    (core_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      in_item <= byte_item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && core_hit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_hit) begin
      result_item <= core_res;
    end
  end

endmodule

// ===== hw/rtl/sqlhl_keyword_match.sv =====
module sqlhl_keyword_match #(
  parameter int MAX_KEYWORD_LEN = sqlhl_pkg::MAX_KEYWORD_LEN_DEFAULT,
  localparam int LEN_BITS = $clog2(MAX_KEYWORD_LEN + 1)
) (
  input  logic [7:0]          word_bytes [MAX_KEYWORD_LEN],
  input  logic [LEN_BITS-1:0] word_length,
  input  logic                word_too_long,
  output sqlhl_pkg::kw_status_t status
);

  logic [sqlhl_pkg::KW_COUNT-1:0] kw_eq;

  // One comparator row per keyword, bytes past the keyword length ignored
  always_comb begin
    for (int k = 0; k < sqlhl_pkg::KW_COUNT; k++) begin
      kw_eq[k] = !word_too_long && (word_length == LEN_BITS'(sqlhl_pkg::KW_LEN[k]));
      for (int i = 0; i < sqlhl_pkg::KW_MAX_LEN; i++) begin
        if (i < int'(sqlhl_pkg::KW_LEN[k]) &&
            word_bytes[i] != sqlhl_pkg::KW_TEXT[k][8*(sqlhl_pkg::KW_MAX_LEN-1-i) +: 8]) begin
          kw_eq[k] = 1'b0;
        end
      end
    end
  end

  // First matching row wins
  always_comb begin
    status.hit         = |kw_eq;
    status.style       = sqlhl_pkg::STYLE_BLUE;
    status.is_member   = kw_eq[sqlhl_pkg::KW_MEMBER];
    status.is_procfunc = kw_eq[sqlhl_pkg::KW_PROCEDURE] | kw_eq[sqlhl_pkg::KW_FUNCTION];
    for (int k = sqlhl_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (kw_eq[k]) begin
        status.style = sqlhl_pkg::KW_STYLE[k];
      end
    end
  end

endmodule

// ===== hw/rtl/sqlhl_lex_core.sv =====
module sqlhl_lex_core #(
  parameter int POS_BITS        = sqlhl_pkg::POS_BITS_DEFAULT,
  parameter int MAX_KEYWORD_LEN = sqlhl_pkg::MAX_KEYWORD_LEN_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  sqlhl_pkg::sqlhl_in_t  item,
  output logic                  res_hit,
  output sqlhl_pkg::sqlhl_out_t res
);

  localparam int LEN_BITS = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int IDX_BITS = $clog2(MAX_KEYWORD_LEN);

  // Lexer state
  sqlhl_pkg::lex_mode_t     lex_mode, lex_mode_next;
  sqlhl_pkg::member_track_t member_track, member_track_next;
  logic [7:0]               prior_byte;
  logic [POS_BITS-1:0]      position, position_next;
  logic [POS_BITS-1:0]      span_start, span_start_next;
  logic [7:0]               word_bytes [MAX_KEYWORD_LEN];
  logic [LEN_BITS-1:0]      word_length, word_length_next;
  logic                     word_too_long, word_too_long_next;

  // State as seen by this byte, after a start of text
  sqlhl_pkg::lex_mode_t     cur_mode, mode_after;
  sqlhl_pkg::member_track_t cur_track;
  logic [7:0]               pred;
  logic [POS_BITS-1:0]      pos, pos_inc, pos_dec, cur_start;
  logic [LEN_BITS-1:0]      cur_length;
  logic                     cur_too_long;
  logic                     is_word;
  logic                     push_en;
  logic [IDX_BITS-1:0]      push_idx;
  logic [7:0]               push_byte;
  sqlhl_pkg::kw_status_t    kw;

  assign cur_mode     = item.start_of_text ? sqlhl_pkg::MODE_IDLE : lex_mode;
  assign cur_track    = item.start_of_text ? sqlhl_pkg::TRK_NONE  : member_track;
  assign pred         = item.start_of_text ? 8'h00 : prior_byte;
  assign pos          = item.start_of_text ? '0 : position;
  assign cur_start    = item.start_of_text ? '0 : span_start;
  assign cur_length   = item.start_of_text ? '0 : word_length;
  assign cur_too_long = item.start_of_text ? 1'b0 : word_too_long;

  assign pos_inc   = (pos == '1) ? pos : pos + 1'b1;
  assign pos_dec   = (pos == '0) ? pos : pos - 1'b1;
  assign is_word   = !sqlhl_pkg::is_delim(item.ch);
  // A new word starts filling the buffer from the first entry
  assign push_idx  = (cur_mode == sqlhl_pkg::MODE_IDLE) ? '0 : cur_length[IDX_BITS-1:0];
  assign push_byte = sqlhl_pkg::to_upper(item.ch);

  sqlhl_keyword_match #(
    .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
  ) u_match (
    .word_bytes   (word_bytes),
    .word_length  (cur_length),
    .word_too_long(cur_too_long),
    .status       (kw)
  );

  // Next state and result for one byte
  always_comb begin
    lex_mode_next      = cur_mode;
    member_track_next  = cur_track;
    position_next      = pos_inc;
    span_start_next    = cur_start;
    word_length_next   = cur_length;
    word_too_long_next = cur_too_long;
    push_en            = 1'b0;
    mode_after         = cur_mode;
    res_hit            = 1'b0;
    res.span_valid        = 1'b0;
    res.span_style        = sqlhl_pkg::STYLE_BLUE;
    res.span_begin        = sqlhl_pkg::OUT_POS_BITS'(cur_start);
    res.span_end          = sqlhl_pkg::OUT_POS_BITS'(pos);
    res.member_name_valid = 1'b0;

    if (is_word) begin
      // Word byte: open a word from idle, or extend the open one
      if (cur_mode == sqlhl_pkg::MODE_IDLE || cur_mode == sqlhl_pkg::MODE_WORD) begin
        if (cur_mode == sqlhl_pkg::MODE_IDLE) begin
          lex_mode_next   = sqlhl_pkg::MODE_WORD;
          span_start_next = pos;
        end
        if (cur_mode == sqlhl_pkg::MODE_IDLE ||
            cur_length < LEN_BITS'(MAX_KEYWORD_LEN)) begin
          push_en          = 1'b1;
          word_length_next = (cur_mode == sqlhl_pkg::MODE_IDLE) ?
                             LEN_BITS'(1) : cur_length + 1'b1;
          if (cur_mode == sqlhl_pkg::MODE_IDLE) begin
            word_too_long_next = 1'b0;
          end
        end else begin
          word_too_long_next = 1'b1;
        end
      end
    end else begin
      // Word end: keyword lookup and member tracking
      if (cur_mode == sqlhl_pkg::MODE_WORD) begin
        mode_after = sqlhl_pkg::MODE_IDLE;
        case (cur_track)
          sqlhl_pkg::TRK_NONE: begin
            if (kw.is_member) begin
              member_track_next = sqlhl_pkg::TRK_MEMBER;
            end
          end
          sqlhl_pkg::TRK_MEMBER: begin
            if (kw.is_procfunc) begin
              member_track_next = sqlhl_pkg::TRK_PROCFUNC;
            end
          end
          default: begin
            member_track_next     = sqlhl_pkg::TRK_NONE;
            res.member_name_valid = 1'b1;
          end
        endcase
        res.span_valid = kw.hit;
        res.span_style = kw.hit ? kw.style : sqlhl_pkg::STYLE_BLUE;
        res_hit        = kw.hit | res.member_name_valid;
      end
      lex_mode_next = mode_after;

      // Comment open and close
      if (mode_after == sqlhl_pkg::MODE_IDLE && item.ch == sqlhl_pkg::CH_STAR &&
          pred == sqlhl_pkg::CH_SLASH) begin
        lex_mode_next   = sqlhl_pkg::MODE_BLOCK;
        span_start_next = pos_dec;
      end else if (mode_after == sqlhl_pkg::MODE_BLOCK && item.ch == sqlhl_pkg::CH_SLASH &&
                   pred == sqlhl_pkg::CH_STAR) begin
        lex_mode_next         = sqlhl_pkg::MODE_IDLE;
        res_hit               = 1'b1;
        res.span_valid        = 1'b1;
        res.span_style        = sqlhl_pkg::STYLE_COMMENT;
        res.span_end          = sqlhl_pkg::OUT_POS_BITS'(pos_inc);
        res.member_name_valid = 1'b0;
      end else if (mode_after == sqlhl_pkg::MODE_IDLE && item.ch == sqlhl_pkg::CH_DASH &&
                   pred == sqlhl_pkg::CH_DASH) begin
        lex_mode_next   = sqlhl_pkg::MODE_LINE;
        span_start_next = pos_dec;
      end else if (mode_after == sqlhl_pkg::MODE_LINE && item.ch == sqlhl_pkg::CH_LF) begin
        lex_mode_next         = sqlhl_pkg::MODE_IDLE;
        res_hit               = 1'b1;
        res.span_valid        = 1'b1;
        res.span_style        = sqlhl_pkg::STYLE_COMMENT;
        res.member_name_valid = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode      <= sqlhl_pkg::MODE_IDLE;
      member_track  <= sqlhl_pkg::TRK_NONE;
      prior_byte    <= 8'h00;
      position      <= '0;
      span_start    <= '0;
      word_length   <= '0;
      word_too_long <= 1'b0;
    end else if (step) begin
      lex_mode      <= lex_mode_next;
      member_track  <= member_track_next;
      prior_byte    <= item.ch;
      position      <= position_next;
      span_start    <= span_start_next;
      word_length   <= word_length_next;
      word_too_long <= word_too_long_next;
    end
  end

  // Word buffer, no reset: only entries below the length are compared
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
      if (step && push_en && push_idx == IDX_BITS'(j)) begin
        word_bytes[j] <= push_byte;
      end
    end
  end

endmodule
